// ----- rtl/cbf_pkg.sv -----
// ---------------------------------------------------------------------------
// cbf_pkg : shared types and constants for the cassette block framer
// Holds the tape format constants, the register map, the result word and
// the sequencer phase encoding.
// ---------------------------------------------------------------------------
package cbf_pkg;

   // Tape format bytes
   localparam logic [7:0] SYNC_BYTE       = 8'h55;
   localparam logic [7:0] MARK_BYTE       = 8'h3C;
   localparam logic [7:0] TYPE_HEADER     = 8'h00;
   localparam logic [7:0] TYPE_DATA       = 8'h01;
   localparam logic [7:0] TYPE_END        = 8'hFF;
   localparam logic [7:0] HEADER_LEN      = 8'd15;
   localparam logic [7:0] END_LEN         = 8'd0;
   localparam logic [7:0] SPACE_CHAR      = 8'h20;
   localparam logic [7:0] PREAMBLE_LENGTH = 8'd128;
   localparam logic [7:0] MAX_BLOCK       = 8'd255;
   localparam logic [7:0] SINGLE_REPEAT   = 8'd1;

   // Header block payload positions
   localparam logic [3:0] HDR_FIRST_IDX = 4'd0;
   localparam logic [3:0] HDR_LAST_IDX  = 4'd14;

   // Register map
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_CHARS    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_LENGTH   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOAD_ADDRESS  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_ADDRESS = 3'd3;

   typedef struct packed {
      logic [63:0] name_chars;
      logic [15:0] data_length;
      logic [15:0] load_address;
      logic [15:0] start_address;
   } csr_regs_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic [7:0] repeat_res;
      logic       last;
      logic       error;
   } rsp_word_type;

   typedef struct packed {
      logic busy;
      logic fire;
   } seq_status_type;

   typedef enum logic [2:0] {
      KIND_HEADER = 3'b001,
      KIND_DATA   = 3'b010,
      KIND_END    = 3'b100
   } block_kind_type;

   typedef enum logic [12:0] {
      PH_IDLE  = 13'b0000000000001,
      PH_FIRST = 13'b0000000000010,
      PH_LEAD  = 13'b0000000000100,
      PH_SYNC  = 13'b0000000001000,
      PH_MARK  = 13'b0000000010000,
      PH_TYPE  = 13'b0000000100000,
      PH_LEN   = 13'b0000001000000,
      PH_HPAY  = 13'b0000010000000,
      PH_DATA  = 13'b0000100000000,
      PH_SUM   = 13'b0001000000000,
      PH_TAIL  = 13'b0010000000000,
      PH_LEAD2 = 13'b0100000000000,
      PH_ERR   = 13'b1000000000000
   } phase_type;

   // Name byte at position idx: uppercase a-z, blank from the first zero on
   function automatic logic [7:0] name_byte(input logic [63:0] name,
                                            input logic [2:0]  idx);
      logic       ended;
      logic [7:0] c;
      logic [7:0] sel;
      ended = 1'b0;
      sel   = SPACE_CHAR;
      for (int i = 0; i < 8; i++) begin
         c = name[8*i +: 8];
         if (c == 8'h00) begin
            ended = 1'b1;
         end
         if (ended) begin
            c = SPACE_CHAR;
         end else if (c >= 8'h61 && c <= 8'h7A) begin
            c = c - 8'h20;
         end
         if (3'(i) == idx) begin
            sel = c;
         end
      end
      return sel;
   endfunction

endpackage

// ----- rtl/cbf_csr.sv -----
// ---------------------------------------------------------------------------
// cbf_csr : configuration registers
// Write-only register file for the file name, data length and addresses.
// ---------------------------------------------------------------------------
module cbf_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [cbf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [63:0]                       csr_wdata,
   output cbf_pkg::csr_regs_type             regs
);
   import cbf_pkg::*;

   csr_regs_type regs_ff;
   csr_regs_type regs_in;

   // Decode the write
   always_comb begin
      regs_in = regs_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_NAME_CHARS:    regs_in.name_chars    = csr_wdata;
            CSR_DATA_LENGTH:   regs_in.data_length   = csr_wdata[15:0];
            CSR_LOAD_ADDRESS:  regs_in.load_address  = csr_wdata[15:0];
            CSR_START_ADDRESS: regs_in.start_address = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign regs = regs_ff;

endmodule

// ----- rtl/cbf_seq.sv -----
// ---------------------------------------------------------------------------
// cbf_seq : block sequencer
// Holds the accepted word and the transfer state and steps through the
// tape bytes it causes, one result per cycle while the output register takes them.
// ---------------------------------------------------------------------------
module cbf_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_action,
   input  logic [7:0]             req_data_byte,
   input  cbf_pkg::csr_regs_type  regs,
   input  logic                   res_take,
   output logic                   res_valid,
   output cbf_pkg::rsp_word_type  res,
   output cbf_pkg::seq_status_type status
);
   import cbf_pkg::*;

   phase_type      phase_ff, phase_in, cur_phase, next_phase;
   block_kind_type kind_ff, kind_in, cur_kind, next_kind;
   logic           action_ff;
   logic [7:0]     byte_ff;
   logic           open_ff, open_in;
   logic [15:0]    bytes_left_ff, bytes_left_in;
   logic [7:0]     block_left_ff, block_left_in;
   logic [7:0]     sum_ff, sum_in;
   logic [3:0]     hdr_idx_ff, hdr_idx_in;
   logic [7:0]     blk_type, blk_len, hdr_byte;
   logic           busy, fire, accept;

   assign busy      = (phase_ff != PH_IDLE);
   assign fire      = busy && res_take;
   assign res_valid = busy;
   assign req_stall = busy && !(fire && res.last);
   assign accept    = req_valid && !req_stall;

   assign status.busy = busy;
   assign status.fire = fire;

   // Resolve the first step of a freshly accepted word
   always_comb begin
      cur_phase = phase_ff;
      cur_kind  = kind_ff;
      if (phase_ff == PH_FIRST) begin
         if (!action_ff) begin
            cur_phase = PH_LEAD;
            cur_kind  = KIND_HEADER;
         end else if (!open_ff) begin
            cur_phase = PH_ERR;
         end else if (block_left_ff == 8'd0) begin
            cur_phase = PH_SYNC;
            cur_kind  = KIND_DATA;
         end else begin
            cur_phase = PH_DATA;
            cur_kind  = KIND_DATA;
         end
      end
   end

   // Type and length of the block being sent
   always_comb begin
      unique case (cur_kind)
         KIND_HEADER: begin
            blk_type = TYPE_HEADER;
            blk_len  = HEADER_LEN;
         end
         KIND_DATA: begin
            blk_type = TYPE_DATA;
            blk_len  = block_left_ff;
         end
         KIND_END: begin
            blk_type = TYPE_END;
            blk_len  = END_LEN;
         end
         default: begin
            blk_type = TYPE_END;
            blk_len  = END_LEN;
         end
      endcase
   end

   // Header block payload
   always_comb begin
      case (hdr_idx_ff)
         4'd0, 4'd1, 4'd2, 4'd3,
         4'd4, 4'd5, 4'd6, 4'd7: hdr_byte = name_byte(regs.name_chars, hdr_idx_ff[2:0]);
         4'd8:    hdr_byte = 8'h02;
         4'd9:    hdr_byte = 8'h00;
         4'd10:   hdr_byte = 8'h01;
         4'd11:   hdr_byte = regs.start_address[15:8];
         4'd12:   hdr_byte = regs.start_address[7:0];
         4'd13:   hdr_byte = regs.load_address[15:8];
         4'd14:   hdr_byte = regs.load_address[7:0];
         default: hdr_byte = 8'h00;
      endcase
   end

   // Produce the current result and the next step
   always_comb begin
      res.byte_value = 8'h00;
      res.repeat_res = SINGLE_REPEAT;
      res.error      = 1'b0;
      next_phase     = PH_IDLE;
      next_kind      = cur_kind;
      open_in        = open_ff;
      bytes_left_in  = bytes_left_ff;
      block_left_in  = block_left_ff;
      sum_in         = sum_ff;
      hdr_idx_in     = hdr_idx_ff;
      unique case (cur_phase)
         PH_LEAD: begin
            res.byte_value = SYNC_BYTE;
            res.repeat_res = PREAMBLE_LENGTH;
            next_phase     = PH_SYNC;
            bytes_left_in  = regs.data_length;
            block_left_in  = 8'd0;
            open_in        = (regs.data_length != 16'd0);
         end
         PH_SYNC: begin
            res.byte_value = SYNC_BYTE;
            next_phase     = PH_MARK;
            if (cur_kind == KIND_DATA) begin
               block_left_in = (bytes_left_ff > {8'h00, MAX_BLOCK}) ?
                               MAX_BLOCK : bytes_left_ff[7:0];
            end
         end
         PH_MARK: begin
            res.byte_value = MARK_BYTE;
            next_phase     = PH_TYPE;
         end
         PH_TYPE: begin
            res.byte_value = blk_type;
            next_phase     = PH_LEN;
         end
         PH_LEN: begin
            res.byte_value = blk_len;
            sum_in         = blk_type + blk_len;
            hdr_idx_in     = HDR_FIRST_IDX;
            if (cur_kind == KIND_HEADER) begin
               next_phase = PH_HPAY;
            end else if (cur_kind == KIND_DATA) begin
               next_phase = PH_DATA;
            end else begin
               next_phase = PH_SUM;
            end
         end
         PH_HPAY: begin
            res.byte_value = hdr_byte;
            sum_in         = sum_ff + hdr_byte;
            hdr_idx_in     = hdr_idx_ff + 4'd1;
            next_phase     = (hdr_idx_ff == HDR_LAST_IDX) ? PH_SUM : PH_HPAY;
         end
         PH_DATA: begin
            res.byte_value = byte_ff;
            sum_in         = sum_ff + byte_ff;
            block_left_in  = block_left_ff - 8'd1;
            bytes_left_in  = bytes_left_ff - 16'd1;
            if (bytes_left_ff == 16'd1) begin
               open_in = 1'b0;
            end
            next_phase     = (block_left_ff == 8'd1) ? PH_SUM : PH_IDLE;
         end
         PH_SUM: begin
            res.byte_value = sum_ff;
            next_phase     = PH_TAIL;
         end
         PH_TAIL: begin
            res.byte_value = SYNC_BYTE;
            if (cur_kind == KIND_HEADER) begin
               next_phase = PH_LEAD2;
            end else if (cur_kind == KIND_DATA && bytes_left_ff == 16'd0) begin
               next_phase = PH_SYNC;
               next_kind  = KIND_END;
            end
         end
         PH_LEAD2: begin
            res.byte_value = SYNC_BYTE;
            res.repeat_res = PREAMBLE_LENGTH;
            if (bytes_left_ff == 16'd0) begin
               next_phase = PH_SYNC;
               next_kind  = KIND_END;
            end
         end
         PH_ERR: begin
            res.error  = 1'b1;
            next_phase = PH_IDLE;
         end
         default: begin
            next_phase = PH_IDLE;
         end
      endcase
      res.last = (next_phase == PH_IDLE);
   end

   // Advance on each delivered result, restart on a new word
   always_comb begin
      phase_in = phase_ff;
      kind_in  = kind_ff;
      if (fire) begin
         phase_in = next_phase;
         kind_in  = next_kind;
      end
      if (accept) begin
         phase_in = PH_FIRST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         kind_ff       <= KIND_HEADER;
         open_ff       <= 1'b0;
         bytes_left_ff <= 16'd0;
         block_left_ff <= 8'd0;
         sum_ff        <= 8'd0;
         hdr_idx_ff    <= HDR_FIRST_IDX;
      end else begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         if (fire) begin
            open_ff       <= open_in;
            bytes_left_ff <= bytes_left_in;
            block_left_ff <= block_left_in;
            sum_ff        <= sum_in;
            hdr_idx_ff    <= hdr_idx_in;
         end
      end
   end

   // Hold the accepted word
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         byte_ff   <= req_data_byte;
      end
   end

endmodule

// ----- rtl/cbf_out.sv -----
// ---------------------------------------------------------------------------
// cbf_out : result register
// Registers each result word and holds it while the receiver stalls.
// ---------------------------------------------------------------------------
module cbf_out (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  res_valid,
   input  cbf_pkg::rsp_word_type res,
   output logic                  res_take,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_byte_value,
   output logic [7:0]            rsp_repeat_res,
   output logic                  rsp_last,
   output logic                  rsp_error
);
   import cbf_pkg::*;

   logic         valid_ff;
   rsp_word_type word_ff;

   // Load when empty or when the held word leaves
   assign res_take = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (res_take) begin
         valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take && res_valid) begin
         word_ff <= res;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_byte_value = word_ff.byte_value;
   assign rsp_repeat_res = word_ff.repeat_res;
   assign rsp_last       = word_ff.last;
   assign rsp_error      = word_ff.error;

endmodule

// ----- rtl/cassette_block_framer.sv -----
// ---------------------------------------------------------------------------
// cassette_block_framer : cassette tape file framer
// Turns a begin word and a stream of program bytes into tape blocks with
// leader runs, headers, checksums and a closing end block.
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   req     | req_valid req_stall req_action         | in
//           | req_data_byte                          |
//   rsp     | rsp_valid rsp_stall rsp_byte_value     | out
//           | rsp_repeat_res rsp_last rsp_error      |
//   csr     | csr_write csr_index csr_wdata          | in
//
// One result word leaves per cycle while the output is not stalled; a word
// causes one result for a data byte inside a block, up to 13 for a data
// byte that opens a block, closes it and closes the file, 23 for a begin,
// 29 for a begin with zero length. The sequencer steps one tape byte per
// cycle while the output register takes it. A new request is taken in the
// cycle its predecessor's last result enters the output register. Synchronous
// reset clears the transfer state, the sequencer, the output valid and the
// configuration registers. A stalled output holds its word and the
// sequencer waits behind it.
// ---------------------------------------------------------------------------
module cassette_block_framer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_action,
   input  logic [7:0]                      req_data_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_byte_value,
   output logic [7:0]                      rsp_repeat_res,
   output logic                            rsp_last,
   output logic                            rsp_error,
   input  logic                            csr_write,
   input  logic [cbf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]                     csr_wdata
);
   import cbf_pkg::*;

   csr_regs_type   regs;
   rsp_word_type   res;
   seq_status_type status;
   logic           res_valid;
   logic           res_take;

   cbf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .regs      (regs)
   );

   cbf_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_data_byte (req_data_byte),
      .regs          (regs),
      .res_take      (res_take),
      .res_valid     (res_valid),
      .res           (res),
      .status        (status)
   );

   cbf_out u_out (
      .clock          (clock),
      .reset          (reset),
      .res_valid      (res_valid),
      .res            (res),
      .res_take       (res_take),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_byte_value (rsp_byte_value),
      .rsp_repeat_res (rsp_repeat_res),
      .rsp_last       (rsp_last),
      .rsp_error      (rsp_error)
   );

   // An error result always closes its word
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (status.fire && res.error) |-> res.last)
      else $error("error result without last");

   // An accepted request keeps the sequencer busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> status.busy)
      else $error("sequencer idle after accept");

   // Only leader runs repeat, and never on an error
   a_repeat: assert property (@(posedge clock) disable iff (reset)
      status.fire |-> ((res.repeat_res == SINGLE_REPEAT) ||
                       (res.repeat_res == PREAMBLE_LENGTH && !res.error)))
      else $error("bad repeat count");

endmodule
